### rtl/rbsi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rbsi_pkg;

	localparam int FX_W          = 32;
	localparam int NUM_W         = FX_W + 1;
	localparam int DIST_W        = 31;
	localparam int MAX_AXES      = 3;
	localparam int CFG_IDX_W     = 3;
	localparam int AXES_DEF      = 3;
	localparam int FRAC_BITS_DEF = 16;

	typedef logic signed [FX_W-1:0]  fx_t;
	typedef logic signed [NUM_W-1:0] num_t;

	localparam fx_t FX_INF  = 32'sh7FFF_FFFF;
	localparam fx_t FX_NINF = 32'sh8000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BOX_LOW_X  = 3'd0,
		REG_BOX_LOW_Y  = 3'd1,
		REG_BOX_LOW_Z  = 3'd2,
		REG_BOX_HIGH_X = 3'd3,
		REG_BOX_HIGH_Y = 3'd4,
		REG_BOX_HIGH_Z = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		fx_t origin_x;
		fx_t origin_y;
		fx_t origin_z;
		fx_t dir_x;
		fx_t dir_y;
		fx_t dir_z;
	} ray_t;

	typedef struct packed {
		logic              hit;
		logic [DIST_W-1:0] near_dist;
		logic [DIST_W-1:0] far_dist;
	} result_t;

endpackage

`default_nettype wire

### rtl/rbsi_div.sv
`timescale 1ns / 1ps
`default_nettype none

module rbsi_div #(
	parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
	input  wire logic        clk,
	input  wire rbsi_pkg::num_t num,
	input  wire rbsi_pkg::fx_t  dir,
	output rbsi_pkg::fx_t       t,
	output logic                t_def
);
	import rbsi_pkg::*;

	localparam int NW    = NUM_W + FRAC_BITS;
	localparam int STEPS = FX_W;

	typedef struct packed {
		logic [NUM_W-1:0] rem;
		logic [FX_W-1:0]  nlo;
		logic [FX_W-1:0]  dmag;
		logic [FX_W-1:0]  quo;
		logic             neg;
		logic             ovf;
		logic             dzero;
		logic             nzero;
		logic             npos;
	} stage_t;

	logic [NUM_W-1:0] num_mag;
	logic [FX_W-1:0]  dir_mag;
	logic [NW-1:0]    nfull;
	logic [NUM_W-1:0] nhigh;
	stage_t           st_s [0:STEPS];
	logic [NUM_W-1:0] trial [1:STEPS];
	logic             take  [1:STEPS];

	always_comb begin
		num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
		dir_mag = dir[FX_W-1] ? FX_W'(-dir) : FX_W'(dir);
		nfull   = {num_mag, {FRAC_BITS{1'b0}}};
		nhigh   = {{(NUM_W-FRAC_BITS-1){1'b0}}, nfull[NW-1:FX_W]};
	end

	always_comb begin
		for (int k = 1; k <= STEPS; k++) begin
			trial[k] = {st_s[k-1].rem[FX_W-1:0], st_s[k-1].nlo[FX_W-1]};
			take[k]  = trial[k] >= {1'b0, st_s[k-1].dmag};
		end
	end

	always_ff @(posedge clk) begin
		st_s[0].rem   <= nhigh;
		st_s[0].nlo   <= nfull[FX_W-1:0];
		st_s[0].dmag  <= dir_mag;
		st_s[0].quo   <= '0;
		st_s[0].neg   <= num[NUM_W-1] ^ dir[FX_W-1];
		st_s[0].ovf   <= nhigh >= {1'b0, dir_mag};
		st_s[0].dzero <= dir == '0;
		st_s[0].nzero <= num == '0;
		st_s[0].npos  <= !num[NUM_W-1];
		for (int k = 1; k <= STEPS; k++) begin
			st_s[k].rem   <= take[k] ? trial[k] - {1'b0, st_s[k-1].dmag} : trial[k];
			st_s[k].nlo   <= {st_s[k-1].nlo[FX_W-2:0], 1'b0};
			st_s[k].dmag  <= st_s[k-1].dmag;
			st_s[k].quo   <= {st_s[k-1].quo[FX_W-2:0], take[k]};
			st_s[k].neg   <= st_s[k-1].neg;
			st_s[k].ovf   <= st_s[k-1].ovf;
			st_s[k].dzero <= st_s[k-1].dzero;
			st_s[k].nzero <= st_s[k-1].nzero;
			st_s[k].npos  <= st_s[k-1].npos;
		end
	end

	stage_t last;
	fx_t    sat;

	always_comb begin
		last = st_s[STEPS];
		if (last.dzero) begin
			sat = last.npos ? FX_INF : FX_NINF;
		end else if (!last.neg) begin
			sat = (last.ovf || last.quo[FX_W-1]) ? FX_INF : fx_t'(last.quo);
		end else begin
			sat = (last.ovf || last.quo > FX_W'(FX_NINF)) ? FX_NINF : fx_t'(-last.quo);
		end
	end

	always_ff @(posedge clk) begin
		t     <= sat;
		t_def <= !(last.dzero && last.nzero);
	end

endmodule

`default_nettype wire

### rtl/ray_box_slab_intersect_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Ray versus axis-aligned box test by the slab method in signed Q16.16. A ray
// is taken in every cycle in which start is high; busy is never raised. Each
// ray gives one transaction on result, marked by done, after the numerator,
// divider, sort, reduce and result registers. Each of the six entry and exit
// distances has its own divider pipeline that resolves one quotient bit per
// stage over 32 stages, with a setup and an output stage. The box corners are
// written through cfg_we, cfg_index and cfg_data and must only change while
// no ray is in flight. done cannot be held off.
module ray_box_slab_intersect_core #(
	parameter int AXES      = rbsi_pkg::AXES_DEF,
	parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire rbsi_pkg::ray_t                      ray,
	output logic                                     done,
	output rbsi_pkg::result_t                        result,
	input  wire logic                                cfg_we,
	input  wire logic [rbsi_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire rbsi_pkg::fx_t                       cfg_data
);
	import rbsi_pkg::*;

	localparam int DIV_LAT = FX_W + 2;
	localparam int LAT     = DIV_LAT + 4;

	fx_t box_low_q  [MAX_AXES];
	fx_t box_high_q [MAX_AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < MAX_AXES; a++) begin
				box_low_q[a]  <= '0;
				box_high_q[a] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_BOX_LOW_X:  box_low_q[0]  <= cfg_data;
				REG_BOX_LOW_Y:  box_low_q[1]  <= cfg_data;
				REG_BOX_LOW_Z:  box_low_q[2]  <= cfg_data;
				REG_BOX_HIGH_X: box_high_q[0] <= cfg_data;
				REG_BOX_HIGH_Y: box_high_q[1] <= cfg_data;
				REG_BOX_HIGH_Z: box_high_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	fx_t org [MAX_AXES];
	fx_t dir [MAX_AXES];

	always_comb begin
		org[0] = ray.origin_x;
		org[1] = ray.origin_y;
		org[2] = ray.origin_z;
		dir[0] = ray.dir_x;
		dir[1] = ray.dir_y;
		dir[2] = ray.dir_z;
	end

	logic valid_s1;
	logic valid_sd [DIV_LAT];
	logic valid_sa;
	logic valid_sb;
	num_t num_lo_s1 [AXES];
	num_t num_hi_s1 [AXES];
	fx_t  dir_s1    [AXES];
	fx_t  ta        [AXES];
	fx_t  tb        [AXES];
	logic va        [AXES];
	logic vb        [AXES];
	fx_t  lo_t_sa   [AXES];
	fx_t  hi_t_sa   [AXES];
	logic lo_v_sa   [AXES];
	logic hi_v_sa   [AXES];

	for (genvar a = 0; a < AXES; a++) begin : g_axis
		always_ff @(posedge clk) begin
			num_lo_s1[a] <= NUM_W'(box_low_q[a]) - NUM_W'(org[a]);
			num_hi_s1[a] <= NUM_W'(box_high_q[a]) - NUM_W'(org[a]);
			dir_s1[a]    <= dir[a];
		end

		rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_lo (
			.clk  (clk),
			.num  (num_lo_s1[a]),
			.dir  (dir_s1[a]),
			.t    (ta[a]),
			.t_def(va[a])
		);

		rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_hi (
			.clk  (clk),
			.num  (num_hi_s1[a]),
			.dir  (dir_s1[a]),
			.t    (tb[a]),
			.t_def(vb[a])
		);

		always_ff @(posedge clk) begin
			if (va[a] && vb[a] && ta[a] > tb[a]) begin
				lo_t_sa[a] <= tb[a];
				hi_t_sa[a] <= ta[a];
			end else begin
				lo_t_sa[a] <= ta[a];
				hi_t_sa[a] <= tb[a];
			end
			lo_v_sa[a] <= va[a];
			hi_v_sa[a] <= vb[a];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			for (int i = 0; i < DIV_LAT; i++) begin
				valid_sd[i] <= 1'b0;
			end
			valid_sa <= 1'b0;
			valid_sb <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s1    <= start;
			valid_sd[0] <= valid_s1;
			for (int i = 1; i < DIV_LAT; i++) begin
				valid_sd[i] <= valid_sd[i-1];
			end
			valid_sa <= valid_sd[DIV_LAT-1];
			valid_sb <= valid_sa;
			done     <= valid_sb;
		end
	end

	fx_t near_c;
	fx_t far_c;
	fx_t near_sb;
	fx_t far_sb;

	always_comb begin
		near_c = FX_NINF;
		far_c  = FX_INF;
		for (int a = 0; a < AXES; a++) begin
			if (lo_v_sa[a] && lo_t_sa[a] > near_c) begin
				near_c = lo_t_sa[a];
			end
			if (hi_v_sa[a] && hi_t_sa[a] < far_c) begin
				far_c = hi_t_sa[a];
			end
		end
	end

	always_ff @(posedge clk) begin
		near_sb <= near_c;
		far_sb  <= far_c;
	end

	fx_t step_near;
	fx_t step_far;

	always_comb begin
		if (near_sb > far_sb) begin
			step_near = FX_INF;
			step_far  = FX_INF;
		end else if (!near_sb[FX_W-1]) begin
			step_near = near_sb;
			step_far  = far_sb;
		end else if (!far_sb[FX_W-1]) begin
			step_near = far_sb;
			step_far  = FX_INF;
		end else begin
			step_near = FX_INF;
			step_far  = FX_INF;
		end
	end

	always_ff @(posedge clk) begin
		result.hit       <= step_near != FX_INF;
		result.near_dist <= step_near[DIST_W-1:0];
		result.far_dist  <= step_far[DIST_W-1:0];
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("ray result did not appear at the fixed latency");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.near_dist <= result.far_dist)
		else $error("near distance beyond far distance");

	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.hit |-> (&result.near_dist) && (&result.far_dist))
		else $error("miss without infinite distances");

endmodule

`default_nettype wire
